// ===== src/vertical_cluster_section_linker_macros.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef VERTICAL_CLUSTER_SECTION_LINKER_MACROS_SVH
`define VERTICAL_CLUSTER_SECTION_LINKER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define VCSL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define VCSL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VCSL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define VCSL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/vcsl_pkg.sv =====
package vcsl_pkg;

   localparam int MAX_SECTIONS = 64;
   localparam int ID_W = $clog2(MAX_SECTIONS);
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
   localparam int DZ_W = 14;
   localparam int SID_W = 6;
   localparam int COORD_W = 32;
   localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(200);

   // One cluster as it is compared and stored.
   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
   } item_type;

   // One section entry held by a cell.
   typedef struct packed {
      logic [ID_W-1:0] id;
      item_type        pos;
   } rec_type;

   // Registered compare results of one cell.
   typedef struct packed {
      logic gap_ok;
      logic ovl;
      logic gt;
   } flags_type;

   // Control from the top level to one cell.
   typedef struct packed {
      logic cmp_en;
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_UPD  = 2'b10
   } state_type;

   // Bit reversal of a per-cell vector.
   function automatic logic [MAX_SECTIONS-1:0] rev_vec(input logic [MAX_SECTIONS-1:0] v);
      logic [MAX_SECTIONS-1:0] r;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         r[i] = v[MAX_SECTIONS-1-i];
      end
      return r;
   endfunction

endpackage

// ===== src/vcsl_req_if.sv =====
interface vcsl_req_if;
   import vcsl_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      start_of_set;
   logic signed [COORD_W-1:0] center_z;
   logic signed [COORD_W-1:0] min_x;
   logic signed [COORD_W-1:0] max_x;
   logic signed [COORD_W-1:0] min_y;
   logic signed [COORD_W-1:0] max_y;
   modport source (output valid, start_of_set, center_z, min_x, max_x, min_y, max_y,
                   input ready);
   modport sink (input valid, start_of_set, center_z, min_x, max_x, min_y, max_y,
                 output ready);
endinterface

// ===== src/vcsl_rsp_if.sv =====
interface vcsl_rsp_if;
   import vcsl_pkg::*;
   logic             valid;
   logic             ready;
   logic [SID_W-1:0] section_id;
   logic             new_section;
   logic             table_full;
   modport source (output valid, section_id, new_section, table_full, input ready);
   modport sink (input valid, section_id, new_section, table_full, output ready);
endinterface

// ===== src/vcsl_cell.sv =====
module vcsl_cell (
   input  logic                      clock,
   input  vcsl_pkg::cell_ctl_type    ctl,
   input  vcsl_pkg::item_type        item,
   input  logic [vcsl_pkg::DZ_W-1:0] dz,
   input  vcsl_pkg::rec_type         nbr,
   input  vcsl_pkg::rec_type         new_rec,
   output vcsl_pkg::rec_type         rec,
   output vcsl_pkg::flags_type       flags
);
   import vcsl_pkg::*;

   rec_type             rec_ff, rec_in;
   flags_type           flags_ff, flags_in;
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]    mag;

   // Compare the broadcast cluster with this cell's entry.
   always_comb begin
      diff = {item.z[COORD_W-1], item.z} - {rec_ff.pos.z[COORD_W-1], rec_ff.pos.z};
      mag = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
      flags_in.gap_ok = mag < {{(COORD_W+1-DZ_W){1'b0}}, dz};
      flags_in.ovl = (item.min_x <= rec_ff.pos.max_x) && (item.max_x >= rec_ff.pos.min_x) &&
                     (item.min_y <= rec_ff.pos.max_y) && (item.max_y >= rec_ff.pos.min_y);
      flags_in.gt = rec_ff.pos.z > item.z;
   end

   // Entry takes the new record, or its upper neighbor's during a reorder.
   always_comb begin
      rec_in = rec_ff;
      if (ctl.load) begin
         rec_in = new_rec;
      end else if (ctl.shift) begin
         rec_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (ctl.cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   assign rec = rec_ff;
   assign flags = flags_ff;

endmodule

// ===== src/vertical_cluster_section_linker.sv =====
// An accepted item is compared and registered at the accept; the update state
// that follows registers the result and reorders the section table.
// No new item is taken in the update state; the cells compare in the accept cycle
// and the section order is updated by a load and a one-step shift along the cell row.
// A result that is not taken holds off the next item until it is taken.
// Reset (synchronous, active high) empties the section table, clears the
// output register and sets delta_z to 200; section contents are not cleared.
`include "vertical_cluster_section_linker_macros.svh"

module vertical_cluster_section_linker (
   input  logic                      clock,
   input  logic                      reset,
   vcsl_req_if.sink                  req_ch,
   vcsl_rsp_if.source                rsp_ch,
   input  logic                      csr_we,
   input  logic [vcsl_pkg::DZ_W-1:0] csr_wdata
);
   import vcsl_pkg::*;

   localparam int N = MAX_SECTIONS;

   state_type         state_ff, state_in;
   logic [DZ_W-1:0]   dz_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff;
   item_type          item_ff, req_item;
   logic              acc;

   logic              rsp_valid_ff;
   logic [SID_W-1:0]  sid_ff, sid_in;
   logic              new_ff, new_in, full_ff, full_in;

   rec_type           recs [N];
   flags_type         flg [N];
   cell_ctl_type      ctl [N];
   rec_type           new_rec;

   logic [N-1:0]      valid_v, stop_v, gt_v, hit_h, above_p, g_v, low_g, dest_d;
   logic [N-1:0]      load_v, shift_v, rev_stop, iso;
   logic [ID_W-1:0]   hit_id;
   logic              found, is_new, upd;
   logic [ID_W+SID_W-1:0] id_ext;

   assign req_item = '{z: req_ch.center_z, min_x: req_ch.min_x, max_x: req_ch.max_x,
                       min_y: req_ch.min_y, max_y: req_ch.max_y};

   // Handshakes.
   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign acc = req_ch.valid && req_ch.ready;
   assign upd = (state_ff == S_UPD);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Search: highest live entry that either is out of range or overlaps.
   always_comb begin
      for (int q = 0; q < N; q++) begin
         valid_v[q] = CNT_W'(q) < n_ff;
         stop_v[q] = valid_v[q] && (!flg[q].gap_ok || flg[q].ovl);
         gt_v[q] = valid_v[q] && flg[q].gt;
      end
      rev_stop = rev_vec(stop_v);
      iso = rev_stop & (~rev_stop + N'(1));
      hit_h = rev_vec(iso);
      found = 1'b0;
      hit_id = '0;
      for (int q = 0; q < N; q++) begin
         if (hit_h[q] && flg[q].gap_ok && flg[q].ovl) begin
            found = 1'b1;
         end
         hit_id = hit_id | (recs[q].id & {ID_W{hit_h[q]}});
      end
      is_new = !found && (n_ff < CNT_W'(N));
   end

   // Reorder: the joined entry moves up past entries not above its new height.
   always_comb begin
      above_p = ~((hit_h << 1) - N'(1));
      g_v = gt_v & above_p;
      low_g = g_v & (~g_v + N'(1));
      if (g_v != '0) begin
         dest_d = low_g >> 1;
      end else begin
         dest_d = N'(1) << (n_ff - CNT_W'(1));
      end
      load_v = '0;
      shift_v = '0;
      if (upd && found) begin
         load_v = dest_d;
         shift_v = (above_p | hit_h) & (dest_d - N'(1));
      end else if (upd && is_new) begin
         load_v = N'(1) << n_ff;
      end
      new_rec.id = found ? hit_id : n_ff[ID_W-1:0];
      new_rec.pos = item_ff;
   end

   // Result and count.
   always_comb begin
      id_ext = {{SID_W{1'b0}}, new_rec.id};
      sid_in = (found || is_new) ? id_ext[SID_W-1:0] : '0;
      new_in = is_new;
      full_in = !found && !is_new;
      count_in = is_new ? n_ff + CNT_W'(1) : n_ff;
   end

   // Row of section cells.
   for (genvar q = 0; q < N; q++) begin : g_cell
      rec_type nbr_rec;
      if (q == N - 1) begin : g_top
         assign nbr_rec = recs[q];
      end else begin : g_mid
         assign nbr_rec = recs[q+1];
      end
      assign ctl[q] = '{cmp_en: acc, shift: shift_v[q], load: load_v[q]};
      vcsl_cell u_cell (
         .clock   (clock),
         .ctl     (ctl[q]),
         .item    (req_item),
         .dz      (dz_ff),
         .nbr     (nbr_rec),
         .new_rec (new_rec),
         .rec     (recs[q]),
         .flags   (flg[q])
      );
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dz_ff <= DZ_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            dz_ff <= csr_wdata;
         end
         if (upd) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (acc) begin
         item_ff <= req_item;
         n_ff <= req_ch.start_of_set ? '0 : count_ff;
      end
      if (upd) begin
         sid_ff <= sid_in;
         new_ff <= new_in;
         full_ff <= full_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.section_id = sid_ff;
   assign rsp_ch.new_section = new_ff;
   assign rsp_ch.table_full = full_ff;

   `VCSL_ASSERT_NEXT(a_acc_upd, clock, reset, acc, state_ff == S_UPD, "accept not followed by update")
   `VCSL_ASSERT_NEXT(a_upd_rsp, clock, reset, upd, rsp_valid_ff, "update gave no result")
   `VCSL_ASSERT_IMPL(a_load_one, clock, reset, upd, $onehot0(load_v), "more than one cell loaded")
   `VCSL_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(N), "section count overflow")
   `VCSL_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_valid_ff, !(new_ff && full_ff), "new and full together")

endmodule
